>>> rtl/kphe_pkg.sv
// Shared constants, types and helpers for the key and encoder event unit.
`timescale 1ns / 1ps

package kphe_pkg;

   localparam int NUM_KEYS  = 16;
   localparam int RUN_WIDTH = 16;
   localparam int SAMPLE_W  = 16;
   localparam int THR_W     = 16;
   localparam int MASK_W    = 17;
   localparam int CODE_W    = 3;
   localparam int NUM_EV    = 5;
   localparam int CSR_IDX_W = 2;
   localparam int KEY_IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int CMP_W     = (RUN_WIDTH > THR_W) ? RUN_WIDTH : THR_W;

   localparam logic [RUN_WIDTH-1:0] RUN_MAX = {RUN_WIDTH{1'b1}};
   localparam logic [KEY_IDX_W-1:0] LAST_KEY = KEY_IDX_W'(NUM_KEYS - 1);

   localparam logic [THR_W-1:0] PRESS_THR_RST   = THR_W'(50);
   localparam logic [THR_W-1:0] HOLD_THR_RST    = THR_W'(500);
   localparam logic [THR_W-1:0] RELEASE_THR_RST = THR_W'(30);

   localparam logic [CSR_IDX_W-1:0] REG_PRESS_THR   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_THR    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE_THR = 2'd2;

   localparam logic [CODE_W-1:0] EV_PRESS    = 3'd0;
   localparam logic [CODE_W-1:0] EV_HOLD     = 3'd1;
   localparam logic [CODE_W-1:0] EV_RELEASE  = 3'd2;
   localparam logic [CODE_W-1:0] EV_CW       = 3'd3;
   localparam logic [CODE_W-1:0] EV_CCW      = 3'd4;

   localparam int ENC_BIT = 16;

   typedef struct packed {
      logic                  load;
      logic                  step;
      logic [KEY_IDX_W-1:0]  key_idx;
      logic                  emit;
      logic [CODE_W-1:0]     emit_code;
      logic                  emit_last;
   } ctl_cmd_type;

   typedef struct packed {
      logic [NUM_EV-1:0] pending;
   } dp_status_type;

   function automatic logic [1:0] gray_pos(input logic [1:0] phase);
      logic [1:0] pos;
      unique case (phase)
         2'd0: pos = 2'd0;
         2'd1: pos = 2'd1;
         2'd3: pos = 2'd2;
         default: pos = 2'd3;
      endcase
      return pos;
   endfunction

   function automatic logic [RUN_WIDTH-1:0] sat_inc(input logic [RUN_WIDTH-1:0] v);
      return (v == RUN_MAX) ? v : v + RUN_WIDTH'(1);
   endfunction

endpackage

>>> rtl/kphe_datapath.sv
// Datapath: thresholds, per-key run counters, encoder state, event masks, result word.
`timescale 1ns / 1ps

module kphe_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [kphe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [kphe_pkg::THR_W-1:0]     csr_write_data,
   input  logic [kphe_pkg::SAMPLE_W-1:0]  req_key_sample,
   input  logic [1:0]                     req_enc_phase,
   input  kphe_pkg::ctl_cmd_type          cmd,
   output kphe_pkg::dp_status_type        status,
   output logic [kphe_pkg::CODE_W-1:0]    rsp_event_code,
   output logic [kphe_pkg::MASK_W-1:0]    rsp_event_mask,
   output logic                           rsp_last_of_tick
);
   import kphe_pkg::*;

   logic [THR_W-1:0] press_thr_ff, hold_thr_ff, release_thr_ff;

   logic [RUN_WIDTH-1:0] ones_ff  [NUM_KEYS];
   logic [RUN_WIDTH-1:0] zeros_ff [NUM_KEYS];
   logic [NUM_KEYS-1:0]  held_ff;

   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [SAMPLE_W-1:0] key_sel_ff, key_sel_in;
   logic [1:0]          enc_prev_ff;
   logic                enc_primed_ff;
   logic [MASK_W-1:0]   mask_ff [NUM_EV];
   logic [MASK_W-1:0]   mask_in [NUM_EV];

   logic [CODE_W-1:0]   code_ff;
   logic [MASK_W-1:0]   rmask_ff;
   logic                last_ff;

   logic                 active;
   logic [RUN_WIDTH-1:0] ones_cur, zeros_cur, ones_in, zeros_in;
   logic                 held_cur, held_in;
   logic                 ev_press, ev_hold, ev_release;
   logic [1:0]           enc_diff;
   logic                 enc_cw, enc_ccw;

   always_comb begin
      active    = sample_ff[0];
      ones_cur  = ones_ff[cmd.key_idx];
      zeros_cur = zeros_ff[cmd.key_idx];
      held_cur  = held_ff[cmd.key_idx];
      ones_in    = '0;
      zeros_in   = '0;
      held_in    = held_cur;
      ev_press   = 1'b0;
      ev_hold    = 1'b0;
      ev_release = 1'b0;
      if (active) begin
         ones_in = sat_inc(ones_cur);
      end else begin
         zeros_in = sat_inc(zeros_cur);
         if (CMP_W'(ones_cur) >= CMP_W'(press_thr_ff) && !held_cur) begin
            ev_press = 1'b1;
         end
      end
      if (!ev_press) begin
         if (held_cur) begin
            if (CMP_W'(zeros_in) >= CMP_W'(release_thr_ff)) begin
               ev_release = 1'b1;
               held_in    = 1'b0;
            end
         end else if (CMP_W'(ones_in) >= CMP_W'(hold_thr_ff)) begin
            ev_hold = 1'b1;
            held_in = 1'b1;
         end
      end
   end

   always_comb begin
      enc_diff = gray_pos(req_enc_phase) - gray_pos(enc_prev_ff);
      enc_cw   = enc_primed_ff && (enc_diff == 2'd1);
      enc_ccw  = enc_primed_ff && (enc_diff == 2'd3);
   end

   always_comb begin
      sample_in  = sample_ff;
      key_sel_in = key_sel_ff;
      for (int c = 0; c < NUM_EV; c++) begin
         mask_in[c] = mask_ff[c];
      end
      if (cmd.load) begin
         sample_in  = req_key_sample;
         key_sel_in = SAMPLE_W'(1);
         for (int c = 0; c < NUM_EV; c++) begin
            mask_in[c] = '0;
         end
         mask_in[EV_CW][ENC_BIT]  = enc_cw;
         mask_in[EV_CCW][ENC_BIT] = enc_ccw;
      end else if (cmd.step) begin
         sample_in  = sample_ff >> 1;
         key_sel_in = key_sel_ff << 1;
         if (ev_press) begin
            mask_in[EV_PRESS] = mask_ff[EV_PRESS] | MASK_W'(key_sel_ff);
         end
         if (ev_hold) begin
            mask_in[EV_HOLD] = mask_ff[EV_HOLD] | MASK_W'(key_sel_ff);
         end
         if (ev_release) begin
            mask_in[EV_RELEASE] = mask_ff[EV_RELEASE] | MASK_W'(key_sel_ff);
         end
      end else if (cmd.emit) begin
         mask_in[cmd.emit_code] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_thr_ff   <= PRESS_THR_RST;
         hold_thr_ff    <= HOLD_THR_RST;
         release_thr_ff <= RELEASE_THR_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_PRESS_THR:   press_thr_ff   <= csr_write_data;
            REG_HOLD_THR:    hold_thr_ff    <= csr_write_data;
            REG_RELEASE_THR: release_thr_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         for (int k = 0; k < NUM_KEYS; k++) begin
            ones_ff[k]  <= '0;
            zeros_ff[k] <= '0;
         end
      end else if (cmd.step) begin
         ones_ff[cmd.key_idx]  <= ones_in;
         zeros_ff[cmd.key_idx] <= zeros_in;
         held_ff[cmd.key_idx]  <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enc_prev_ff   <= '0;
         enc_primed_ff <= 1'b0;
         for (int c = 0; c < NUM_EV; c++) begin
            mask_ff[c] <= '0;
         end
      end else begin
         if (cmd.load) begin
            enc_prev_ff   <= req_enc_phase;
            enc_primed_ff <= 1'b1;
         end
         for (int c = 0; c < NUM_EV; c++) begin
            mask_ff[c] <= mask_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      sample_ff  <= sample_in;
      key_sel_ff <= key_sel_in;
      if (cmd.emit) begin
         code_ff  <= cmd.emit_code;
         rmask_ff <= mask_ff[cmd.emit_code];
         last_ff  <= cmd.emit_last;
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_EV; c++) begin
         status.pending[c] = |mask_ff[c];
      end
   end

   assign rsp_event_code   = code_ff;
   assign rsp_event_mask   = rmask_ff;
   assign rsp_last_of_tick = last_ff;

endmodule

>>> rtl/kphe_controller.sv
// Controller: accepts a sample word, walks the keys, then issues result words.
`timescale 1ns / 1ps

module kphe_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  kphe_pkg::dp_status_type  status,
   output kphe_pkg::ctl_cmd_type    cmd
);
   import kphe_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [KEY_IDX_W-1:0] idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 slot_free;
   logic [CODE_W-1:0]    top_code;
   logic [NUM_EV-1:0]    rest;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      top_code = EV_PRESS;
      priority if (status.pending[EV_CCW])     top_code = EV_CCW;
      else if (status.pending[EV_CW])          top_code = EV_CW;
      else if (status.pending[EV_RELEASE])     top_code = EV_RELEASE;
      else if (status.pending[EV_HOLD])        top_code = EV_HOLD;
      else                                     top_code = EV_PRESS;
      rest = status.pending;
      rest[top_code] = 1'b0;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmd          = '0;
      cmd.key_idx  = idx_ff;
      cmd.emit_code = top_code;
      cmd.emit_last = (rest == '0);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            idx_in   = idx_ff + KEY_IDX_W'(1);
            if (idx_ff == LAST_KEY) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.pending == '0) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/key_press_hold_and_encoder_events_unit.sv
// Top level: key press/hold detector with quadrature encoder decoder.
//
// Input channel (req_): one word per sampling tick, a 16-bit key sample and
// a 2-bit encoder phase, taken when req_valid is high and req_stall is low.
// Result channel (rsp_): one word per event kind seen in the tick, codes in
// descending order (counter-clockwise, clockwise, hold release, hold, press),
// each with a 17-bit mask; rsp_last_of_tick marks the final word of a tick.
// A tick with no events gives no word.
// Configuration (csr_): write-only thresholds, index 0 press, 1 hold,
// 2 hold release; write only while idle.
// Timing: after the accept edge the key counters are walked one key per
// cycle (one shared compare unit), then the result words are issued in
// turn from the output register once the walk is done. A tick holds the
// unit until all its results are issued.
// The next word is taken while the last result still waits in the output
// register. A stalled result holds; issue of later results waits for it.
// Reset: thresholds go to 50/500/30, all counters and hold flags clear, and
// the encoder is unprimed, so the first tick only stores its phase.
`timescale 1ns / 1ps

module key_press_hold_and_encoder_events_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [kphe_pkg::SAMPLE_W-1:0]  req_key_sample,
   input  logic [1:0]                     req_enc_phase,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [kphe_pkg::CODE_W-1:0]    rsp_event_code,
   output logic [kphe_pkg::MASK_W-1:0]    rsp_event_mask,
   output logic                           rsp_last_of_tick,
   input  logic                           csr_write_enable,
   input  logic [kphe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [kphe_pkg::THR_W-1:0]     csr_write_data
);
   import kphe_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   kphe_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   kphe_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_key_sample   (req_key_sample),
      .req_enc_phase    (req_enc_phase),
      .cmd              (cmd),
      .status           (status),
      .rsp_event_code   (rsp_event_code),
      .rsp_event_mask   (rsp_event_mask),
      .rsp_last_of_tick (rsp_last_of_tick)
   );

endmodule
